// ===== hw/rtl/sha256bsh_pkg.sv =====
package sha256bsh_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_COMP,
        ST_FEED,
        ST_OUT
    } state_t;

    // Controls for the working variables and the chaining value.
    typedef struct packed {
        logic init;
        logic load;
        logic step;
        logic feed;
    } round_ctrl_t;

    // Controls for the block buffer / message schedule window.
    typedef struct packed {
        logic shift_byte;
        logic step;
    } sched_ctrl_t;

    localparam logic [5:0]  LEN_FILL      = 6'd56;
    localparam logic [5:0]  LAST_FILL     = 6'd63;
    localparam logic [5:0]  LAST_ROUND    = 6'd63;
    localparam logic [2:0]  LAST_WORD_IDX = 3'd7;
    localparam logic [7:0]  PAD_MARK      = 8'h80;
    localparam logic [63:0] BLOCK_BITS    = 64'd512;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        logic [63:0] dbl;
        dbl = {x, x} >> n;
        return dbl[31:0];
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

// ===== hw/rtl/sha256bsh_sched.sv =====
module sha256bsh_sched
    import sha256bsh_pkg::*;
(
    input  logic        clk,
    input  sched_ctrl_t ctrl,
    input  logic [7:0]  byte_in,
    output logic [31:0] w
);

    // Sixteen words that first collect the block bytes and then roll as the
    // schedule window: entry i holds W[t+i] during round t.
    logic [31:0] win_reg  [16];
    logic [31:0] win_next [16];
    logic [31:0] new_w;

    always_comb
    begin
        new_w = win_reg[0] + small_sigma0(win_reg[1]) + win_reg[9]
              + small_sigma1(win_reg[14]);
        for (int i = 0; i < 16; i++)
        begin
            win_next[i] = win_reg[i];
        end
        if (ctrl.shift_byte)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_next[i] = {win_reg[i][23:0], win_reg[i + 1][31:24]};
            end
            win_next[15] = {win_reg[15][23:0], byte_in};
        end
        else if (ctrl.step)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_next[i] = win_reg[i + 1];
            end
            win_next[15] = new_w;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    assign w = win_reg[0];

endmodule

// ===== hw/rtl/sha256bsh_round.sv =====
module sha256bsh_round
    import sha256bsh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  round_ctrl_t       ctrl,
    input  logic [31:0]       w,
    input  logic [31:0]       k,
    output logic [7:0][31:0]  hash
);

    logic [31:0] hash_reg  [8];
    logic [31:0] hash_next [8];
    logic [31:0] v_reg     [8];
    logic [31:0] v_next    [8];
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    always_comb
    begin
        ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1  = v_reg[7] + big_sigma1(v_reg[4]) + ch + k + w;
        t2  = big_sigma0(v_reg[0]) + maj;

        for (int i = 0; i < 8; i++)
        begin
            v_next[i]    = v_reg[i];
            hash_next[i] = hash_reg[i];
        end

        if (ctrl.load)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_next[i] = hash_reg[i];
            end
        end
        else if (ctrl.step)
        begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
        end

        if (ctrl.init)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_next[i] = H_INIT[i];
            end
        end
        else if (ctrl.feed)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_next[i] = hash_reg[i] + v_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= H_INIT[i];
            end
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            hash[i] = hash_reg[i];
        end
    end

endmodule

// ===== hw/rtl/sha256_byte_stream_hasher_core.sv =====
// SHA-256 hasher that takes a message one byte per item.
// Input channel s_*: s_tuser low absorbs the byte in s_tdata[7:0]; s_tuser high
// finishes the message (the data byte is ignored) and starts the digest.
// Output channel m_*: eight items per finished message, the digest words most
// significant first, each with its index; m_tlast marks the eighth word.
// An absorb item shifts its byte into the block buffer. The item that completes
// a 64-byte block also runs the compression: one round per cycle on a single
// shared round unit, 64 rounds and then a feed-forward step into the hash.
// A finish item shifts the padding and the length into the block buffer one byte
// per cycle (at most 8 + 56 + 8 bytes, with no byte shifted on the step into the
// length) and compresses one or two blocks; the digest words follow the last
// feed-forward step.
// s_tready is high only while the block waits for an item; it is low during
// compression, padding and while digest words are pending.
// Digest words are held in the chaining registers; a stalled receiver simply
// keeps m_tvalid high with the same word until it takes it.
// After the last word is taken, the hash state returns to the initial values.
// Reset (rst_n low) restores the initial hash state and an empty buffer.
module sha256_byte_stream_hasher_core
    import sha256bsh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zeros above
    output logic        m_tlast    // last_word
);

    state_t      state_reg;
    state_t      state_next;
    logic [5:0]  fill_reg;
    logic [5:0]  fill_next;
    logic [63:0] bit_total_reg;
    logic [63:0] bit_total_next;
    logic [63:0] len_reg;
    logic [63:0] len_next;
    logic [5:0]  round_reg;
    logic [5:0]  round_next;
    logic [2:0]  out_idx_reg;
    logic [2:0]  out_idx_next;
    logic        finish_reg;
    logic        finish_next;
    logic        pad_first_reg;
    logic        pad_first_next;
    logic        len_sent_reg;
    logic        len_sent_next;

    logic        accept;
    logic        out_accept;
    logic        pad_shift;
    logic [7:0]  shift_data;
    sched_ctrl_t sched_ctrl;
    round_ctrl_t round_ctrl;
    logic [31:0] w;
    logic [7:0][31:0] hash;

    assign accept     = s_tvalid && s_tready;
    assign out_accept = m_tvalid && m_tready;
    // While padding, the 0x80 marker and then zeros are shifted until the length field position is reached.
    assign pad_shift  = pad_first_reg || (fill_reg != LEN_FILL);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser)
                    begin
                        state_next = ST_PAD;
                    end
                    else if (fill_reg == LAST_FILL)
                    begin
                        state_next = ST_COMP;
                    end
                end
            end
            ST_PAD:
            begin
                if (pad_shift)
                begin
                    if (fill_reg == LAST_FILL)
                    begin
                        state_next = ST_COMP;
                    end
                end
                else
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (fill_reg == LAST_FILL)
                begin
                    state_next = ST_COMP;
                end
            end
            ST_COMP:
            begin
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_FEED;
                end
            end
            ST_FEED:
            begin
                if (!finish_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (len_sent_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_OUT:
            begin
                if (m_tready && (out_idx_reg == LAST_WORD_IDX))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs.
    always_comb
    begin
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        sched_ctrl = '0;
        round_ctrl = '0;
        shift_data = s_tdata;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready              = 1'b1;
                sched_ctrl.shift_byte = s_tvalid && !s_tuser;
            end
            ST_PAD:
            begin
                sched_ctrl.shift_byte = pad_shift;
                shift_data            = pad_first_reg ? PAD_MARK : 8'h00;
            end
            ST_LEN:
            begin
                sched_ctrl.shift_byte = 1'b1;
                shift_data            = len_reg[63:56];
            end
            ST_COMP:
            begin
                sched_ctrl.step = 1'b1;
                round_ctrl.step = 1'b1;
            end
            ST_FEED:
            begin
                round_ctrl.feed = 1'b1;
            end
            ST_OUT:
            begin
                m_tvalid        = 1'b1;
                round_ctrl.init = m_tready && (out_idx_reg == LAST_WORD_IDX);
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
        // The working variables pick up the chaining value as the block completes.
        round_ctrl.load = (state_reg != ST_COMP) && (state_next == ST_COMP);
    end

    // Counters and message bookkeeping.
    always_comb
    begin
        fill_next      = fill_reg;
        bit_total_next = bit_total_reg;
        len_next       = len_reg;
        round_next     = 6'd0;
        out_idx_next   = out_idx_reg;
        finish_next    = finish_reg;
        pad_first_next = pad_first_reg;
        len_sent_next  = len_sent_reg;

        if (sched_ctrl.shift_byte)
        begin
            fill_next = fill_reg + 6'd1;
        end
        if (state_reg == ST_COMP)
        begin
            round_next = round_reg + 6'd1;
        end
        if (accept && !s_tuser && (fill_reg == LAST_FILL))
        begin
            bit_total_next = bit_total_reg + BLOCK_BITS;
        end
        if (accept && s_tuser)
        begin
            len_next       = bit_total_reg + {55'd0, fill_reg, 3'd0};
            finish_next    = 1'b1;
            pad_first_next = 1'b1;
            len_sent_next  = 1'b0;
        end
        if ((state_reg == ST_PAD) && pad_first_reg)
        begin
            pad_first_next = 1'b0;
        end
        if (state_reg == ST_LEN)
        begin
            len_next = {len_reg[55:0], 8'h00};
            if (fill_reg == LAST_FILL)
            begin
                len_sent_next = 1'b1;
            end
        end
        if (out_accept)
        begin
            out_idx_next = out_idx_reg + 3'd1;
        end
        if (round_ctrl.init)
        begin
            fill_next      = 6'd0;
            bit_total_next = 64'd0;
            finish_next    = 1'b0;
            len_sent_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= 6'd0;
            bit_total_reg <= 64'd0;
            round_reg     <= 6'd0;
            out_idx_reg   <= 3'd0;
            finish_reg    <= 1'b0;
            pad_first_reg <= 1'b0;
            len_sent_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            bit_total_reg <= bit_total_next;
            round_reg     <= round_next;
            out_idx_reg   <= out_idx_next;
            finish_reg    <= finish_next;
            pad_first_reg <= pad_first_next;
            len_sent_reg  <= len_sent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
    end

    sha256bsh_sched u_sched (
        .clk     (clk),
        .ctrl    (sched_ctrl),
        .byte_in (shift_data),
        .w       (w)
    );

    sha256bsh_round u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (round_ctrl),
        .w     (w),
        .k     (K_TABLE[round_reg]),
        .hash  (hash)
    );

    assign m_tdata = {5'd0, out_idx_reg, hash[out_idx_reg]};
    assign m_tlast = (out_idx_reg == LAST_WORD_IDX);

endmodule
